[rtl/nsmr_pkg.sv]
package nsmr_pkg;

  localparam int unsigned SumW   = 48;
  localparam int unsigned CountW = 17;
  localparam int unsigned CfgW   = 21;
  localparam int unsigned IdxCfgW = 2;

  localparam logic [IdxCfgW-1:0] RegInnerSize   = 2'd0;
  localparam logic [IdxCfgW-1:0] RegReduceLen   = 2'd1;
  localparam logic [IdxCfgW-1:0] RegOuterCount  = 2'd2;
  localparam logic [IdxCfgW-1:0] RegComplexMode = 2'd3;

  typedef struct packed {
    logic signed [31:0] sample_real;
    logic signed [31:0] sample_imag;
    logic               real_missing;
    logic               imag_missing;
  } in_t;

  typedef struct packed {
    logic signed [31:0] mean_real;
    logic signed [31:0] mean_imag;
    logic [16:0]        present_count;
    logic               all_missing;
    logic               last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic div_done;
  } stat_t;

endpackage

[rtl/nan_skipping_mean_reduce.sv]
// Mean along one dimension of a column-major array, skipping missing samples.
// Input words arrive on in_valid_i/in_ready_o in column-major order; each
// word carries a Q16.16 real and imaginary part and their missing flags.
// Result words leave on out_valid_o/out_ready_i, one per reduced slice, after
// the last sample of that slice; last marks the final word of the array.
// Sizes and complex mode are set through the write port (cfg_we_i, cfg_idx_i,
// cfg_data_i); the user must do so only while the block is idle, as the block
// itself does not enforce it; any write restarts the array. A word that ends
// no slice passes through accept, slot memory read and the write back of the
// updated sum and count. A word that ends a slice then goes through the
// bit-serial divider and a load of the output register before its result appears.
// The output register holds a word until it is taken; meanwhile further
// samples are accepted, and only a second finished result waits for it.
// Reset returns the sizes to one, real mode and the start of the array; the
// slot memory is not cleared, as the first sample of a slice ignores its slot.
module nan_skipping_mean_reduce
  import nsmr_pkg::*;
#(
  parameter int unsigned MAX_INNER   = 4096,
  parameter int unsigned MAX_REDUCE  = 65536,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IdxCfgW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  nsmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  nsmr_dp #(
    .MAX_INNER   (MAX_INNER),
    .MAX_REDUCE  (MAX_REDUCE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

[rtl/nsmr_ctrl.sv]
module nsmr_ctrl
  import nsmr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StUpd  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    oval_d  = oval_q;
    cmd_o   = '0;
    in_ready_o = 1'b0;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = StRead;
        end
      end
      StRead: state_d = StUpd;
      StUpd: begin
        cmd_o.update = 1'b1;
        state_d = stat_i.emit ? StDiv : StIdle;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        // The finished word waits here until the output register is free.
        if (!oval_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          oval_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o = oval_q;

endmodule

[rtl/nsmr_dp.sv]
module nsmr_dp
  import nsmr_pkg::*;
#(
  parameter int unsigned MAX_INNER   = 4096,
  parameter int unsigned MAX_REDUCE  = 65536,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IdxCfgW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  in_t                in_data_i,
  output out_t               out_data_o,
  input  cmd_t               cmd_i,
  output stat_t              stat_o
);

  localparam int unsigned IdxW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned RedW = (MAX_REDUCE > 1) ? $clog2(MAX_REDUCE) : 1;
  localparam int unsigned EntW = 2 * SumW + CountW;
  localparam int unsigned DivCntW = $clog2(SumW);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(SumW - 1);

  logic [12:0] inner_size_q;
  logic [16:0] reduce_len_q;
  logic [20:0] outer_count_q;
  logic        cplx_q;

  logic [IdxW-1:0] inner_pos_q;
  logic [RedW-1:0] reduce_pos_q;
  logic [20:0]     outer_pos_q;

  logic [IdxW-1:0] n_in_m1;
  logic [RedW-1:0] n_red_m1;
  logic [20:0]     n_out_m1;
  logic            inner_last, red_last, outer_last;

  always_comb begin
    if (inner_size_q == '0) begin
      n_in_m1 = '0;
    end else if (32'(inner_size_q) > MAX_INNER) begin
      n_in_m1 = IdxW'(MAX_INNER - 1);
    end else begin
      n_in_m1 = IdxW'(32'(inner_size_q) - 32'd1);
    end
    if (reduce_len_q == '0) begin
      n_red_m1 = '0;
    end else if (32'(reduce_len_q) > MAX_REDUCE) begin
      n_red_m1 = RedW'(MAX_REDUCE - 1);
    end else begin
      n_red_m1 = RedW'(32'(reduce_len_q) - 32'd1);
    end
    n_out_m1 = (outer_count_q == '0) ? '0 : outer_count_q - 21'd1;
  end

  assign inner_last = inner_pos_q == n_in_m1;
  assign red_last   = reduce_pos_q == n_red_m1;
  assign outer_last = outer_pos_q == n_out_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_size_q  <= 13'd1;
      reduce_len_q  <= 17'd1;
      outer_count_q <= 21'd1;
      cplx_q        <= 1'b0;
      inner_pos_q   <= '0;
      reduce_pos_q  <= '0;
      outer_pos_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegInnerSize:   inner_size_q  <= cfg_data_i[12:0];
        RegReduceLen:   reduce_len_q  <= cfg_data_i[16:0];
        RegOuterCount:  outer_count_q <= cfg_data_i[20:0];
        RegComplexMode: cplx_q        <= cfg_data_i[0];
        default: ;
      endcase
      inner_pos_q  <= '0;
      reduce_pos_q <= '0;
      outer_pos_q  <= '0;
    end else if (cmd_i.accept) begin
      if (inner_last) begin
        inner_pos_q <= '0;
        if (red_last) begin
          reduce_pos_q <= '0;
          outer_pos_q  <= outer_last ? '0 : outer_pos_q + 21'd1;
        end else begin
          reduce_pos_q <= reduce_pos_q + 1'b1;
        end
      end else begin
        inner_pos_q <= inner_pos_q + 1'b1;
      end
    end
  end

  // Sign extension from the low sample bits of a field.
  function automatic logic [SumW-1:0] sext(input logic [31:0] v);
    logic [SumW-1:0] z;
    logic [SumW-1:0] r;
    z = SumW'(v);
    for (int i = 0; i < SumW; i++) begin
      r[i] = (i < SAMPLE_BITS) ? z[i] : z[SAMPLE_BITS-1];
    end
    return r;
  endfunction

  logic [SumW-1:0] smp_re_q, smp_im_q;
  logic            pres_q, first_q, emit_q, lastf_q;
  logic [IdxW-1:0] slot_q;
  logic [EntW-1:0] mem [MAX_INNER];
  logic [EntW-1:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q <= 1'b0;
    end else if (cmd_i.accept) begin
      emit_q <= red_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_re_q <= sext(in_data_i.sample_real);
      smp_im_q <= cplx_q ? sext(in_data_i.sample_imag) : '0;
      pres_q   <= !in_data_i.real_missing && !(cplx_q && in_data_i.imag_missing);
      first_q  <= reduce_pos_q == '0;
      lastf_q  <= inner_last && outer_last;
      slot_q   <= inner_pos_q;
      rd_q     <= mem[inner_pos_q];
    end
  end

  logic [SumW-1:0]   base_re, base_im, new_re, new_im;
  logic [CountW-1:0] base_cnt, new_cnt;

  always_comb begin
    if (first_q) begin
      base_re  = '0;
      base_im  = '0;
      base_cnt = '0;
    end else begin
      base_re  = rd_q[EntW-1 -: SumW];
      base_im  = rd_q[CountW +: SumW];
      base_cnt = rd_q[CountW-1:0];
    end
    if (pres_q) begin
      new_re  = base_re + smp_re_q;
      new_im  = base_im + smp_im_q;
      new_cnt = base_cnt + 1'b1;
    end else begin
      new_re  = base_re;
      new_im  = base_im;
      new_cnt = base_cnt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      mem[slot_q] <= {new_re, new_im, new_cnt};
    end
  end

  // Two restoring dividers share one step counter; magnitudes are divided and
  // the sign is put back afterwards, which truncates toward zero.
  logic [SumW-1:0]    dvd_re_q, dvd_im_q;
  logic [CountW-1:0]  rem_re_q, rem_im_q, den_q;
  logic               neg_re_q, neg_im_q, dlast_q;
  logic [DivCntW-1:0] dcnt_q;
  logic [CountW:0]    tr_re, tr_im;
  logic               ge_re, ge_im;

  assign tr_re = {rem_re_q, dvd_re_q[SumW-1]};
  assign tr_im = {rem_im_q, dvd_im_q[SumW-1]};
  assign ge_re = tr_re >= {1'b0, den_q};
  assign ge_im = tr_im >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      neg_re_q <= new_re[SumW-1];
      neg_im_q <= new_im[SumW-1];
      dvd_re_q <= new_re[SumW-1] ? -new_re : new_re;
      dvd_im_q <= new_im[SumW-1] ? -new_im : new_im;
      rem_re_q <= '0;
      rem_im_q <= '0;
      den_q    <= new_cnt;
      dlast_q  <= lastf_q;
      dcnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      dvd_re_q <= {dvd_re_q[SumW-2:0], ge_re};
      dvd_im_q <= {dvd_im_q[SumW-2:0], ge_im};
      rem_re_q <= ge_re ? CountW'(tr_re - {1'b0, den_q}) : tr_re[CountW-1:0];
      rem_im_q <= ge_im ? CountW'(tr_im - {1'b0, den_q}) : tr_im[CountW-1:0];
      dcnt_q   <= dcnt_q + 1'b1;
    end
  end

  logic [31:0] q_re, q_im;
  assign q_re = neg_re_q ? -dvd_re_q[31:0] : dvd_re_q[31:0];
  assign q_im = neg_im_q ? -dvd_im_q[31:0] : dvd_im_q[31:0];

  out_t out_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.mean_real     <= (den_q == '0) ? '0 : q_re;
      out_q.mean_imag     <= (den_q == '0) ? '0 : q_im;
      out_q.present_count <= den_q;
      out_q.all_missing   <= den_q == '0;
      out_q.last          <= dlast_q;
    end
  end

  assign out_data_o      = out_q;
  assign stat_o.emit     = emit_q;
  assign stat_o.div_done = dcnt_q == DivLast;

endmodule
